[rtl/core/lpr_pkg.sv]
package lpr_pkg;

    localparam int FIDX_W  = 3;
    localparam int FAULT_W = 32;
    localparam int OUT_W   = 40;
    localparam int USER_W  = 2;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // per-entry verdict of the shared compare unit
    typedef struct packed {
        logic match;     // valid and page equal to the key
        logic empty;     // frame holds nothing
        logic above;     // valid and rank above the current best
        logic age;       // rank moves up by one on this touch
    } t_unit_res;

endpackage

[rtl/core/lpr_ram.sv]
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lpr_unit.sv]
module lpr_unit #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int RANK_W    = 3
) (
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [RANK_W-1:0]    i_rank,
    input  logic                 i_valid,
    input  logic [PAGE_BITS-1:0] i_key,
    input  logic [RANK_W-1:0]    i_best,
    input  logic [RANK_W:0]      i_older,
    input  logic                 i_target,
    output lpr_pkg::t_unit_res   o_res,
    output logic [RANK_W-1:0]    o_rank_next
);

    localparam logic [RANK_W-1:0] RankMax = RANK_W'(FRAMES - 1);

    always_comb begin
        o_res.match = i_valid && (i_page == i_key);
        o_res.empty = !i_valid;
        o_res.above = i_valid && (i_rank > i_best);
        // saturate at the oldest rank
        o_res.age   = i_valid && !i_target && ({1'b0, i_rank} < i_older)
                      && (i_rank != RankMax);
        o_rank_next = i_rank + RANK_W'(1);
    end

endmodule

[rtl/core/lru_page_replacement.sv]
// LRU page replacement engine.
// Slave stream: one page reference per transaction, page number in the low
// PAGE_BITS of s_axis_tdata. Master stream: one result per reference, hit
// and filled-empty flags in m_axis_tuser, frame index and saturating fault
// total in m_axis_tdata. Config channel: writes the active frame count,
// taken whenever i_cfg_valid is high; write it only while the block is idle.
// Frame pages and ranks live in one RAM with a registered read port. A
// reference runs two sweeps over the n active frames through one compare
// unit: a scan that finds hit, first empty frame and oldest frame, then a
// rank update that writes the chosen frame and ages the younger valid
// entries. s_axis_tready is low while a reference is in progress and rises
// as its result is registered, so a new reference is taken only once the
// previous one is through. The result register holds while m_axis_tready
// is low; a reference that completes while the previous result still waits
// holds at the end of its rank sweep until the receiver takes that result.
// Reset (synchronous, active low) empties all frames, clears the fault
// count and sets the active frame count to three; no clearing pass is needed.
module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [3:0]                 i_cfg_data,     // frames_in_use
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0] s_axis_tdata, // page_number
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [lpr_pkg::OUT_W-1:0]  m_axis_tdata,   // frame_index, fault_total
    output logic [lpr_pkg::USER_W-1:0] m_axis_tuser    // hit, filled_empty
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int WORD_W = PAGE_BITS + RANK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD
    } t_state;

    t_state                    r_state;
    logic [3:0]                r_fiu;
    logic [CNT_W-1:0]          r_n;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_dv;
    logic [IDX_W-1:0]          r_eidx;
    logic [PAGE_BITS-1:0]      r_key;
    logic [FRAMES-1:0]         r_valid;
    logic                      r_hit;
    logic [IDX_W-1:0]          r_hit_idx;
    logic [RANK_W-1:0]         r_hit_rank;
    logic                      r_emp;
    logic [IDX_W-1:0]          r_emp_idx;
    logic [RANK_W-1:0]         r_best;
    logic [IDX_W-1:0]          r_vic;
    logic [IDX_W-1:0]          r_f;
    logic [RANK_W:0]           r_older;
    logic [lpr_pkg::FAULT_W-1:0] r_fault;
    logic                      r_out_v;
    logic                      r_o_hit;
    logic                      r_o_fill;
    logic [lpr_pkg::FIDX_W-1:0] r_o_idx;
    logic [lpr_pkg::FAULT_W-1:0] r_o_fault;

    logic [CNT_W-1:0]          n_n;
    logic [lpr_pkg::FAULT_W-1:0] n_fault;
    logic                      upd_done;
    logic                      rd_en;
    logic                      we;
    logic [WORD_W-1:0]         wdata;
    logic [WORD_W-1:0]         rdata;
    logic [PAGE_BITS-1:0]      e_page;
    logic [RANK_W-1:0]         e_rank;
    logic [RANK_W-1:0]         rank_next;
    logic                      e_target;
    lpr_pkg::t_unit_res        res;
    logic [IDX_W+lpr_pkg::FIDX_W-1:0] f_ext;

    // clamp the configured count into 1..FRAMES
    always_comb begin
        if (r_fiu == 4'd0) begin
            n_n = CNT_W'(1);
        end else if (32'(r_fiu) > FRAMES) begin
            n_n = CNT_W'(FRAMES);
        end else begin
            n_n = CNT_W'(r_fiu);
        end
    end

    always_comb begin
        n_fault = r_fault;
        if (!r_hit && (r_fault != lpr_pkg::FAULT_MAX)) begin
            n_fault = r_fault + lpr_pkg::FAULT_W'(1);
        end
    end

    assign e_page   = rdata[PAGE_BITS-1:0];
    assign e_rank   = rdata[WORD_W-1:PAGE_BITS];
    assign e_target = (r_eidx == r_f);
    assign rd_en    = ((r_state == ST_SCAN) || (r_state == ST_UPD)) && (r_idx < r_n);
    // hold the finished reference until the result register is free
    assign upd_done = (r_state == ST_UPD) && !r_dv && (r_idx == r_n)
                      && (!r_out_v || m_axis_tready);

    lpr_unit #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .RANK_W    (RANK_W)
    ) u_unit (
        .i_page      (e_page),
        .i_rank      (e_rank),
        .i_valid     (r_valid[r_eidx]),
        .i_key       (r_key),
        .i_best      (r_best),
        .i_older     (r_older),
        .i_target    (e_target),
        .o_res       (res),
        .o_rank_next (rank_next)
    );

    // rank sweep: touched frame gets rank 0 and the new page, younger valid frames age
    always_comb begin
        we    = 1'b0;
        wdata = rdata;
        if ((r_state == ST_UPD) && r_dv) begin
            if (e_target) begin
                we    = 1'b1;
                wdata = {{RANK_W{1'b0}}, r_key};
            end else if (res.age) begin
                we    = 1'b1;
                wdata = {rank_next, e_page};
            end
        end
    end

    lpr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAMES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_eidx),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign f_ext = {{lpr_pkg::FIDX_W{1'b0}}, r_f};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fiu   <= 4'd3;
            r_valid <= '0;
            r_fault <= '0;
            r_dv    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fiu <= i_cfg_data;
            end
            if (upd_done) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_key  <= s_axis_tdata[PAGE_BITS-1:0];
                        r_n    <= n_n;
                        r_idx  <= '0;
                        r_dv   <= 1'b0;
                        r_hit  <= 1'b0;
                        r_emp  <= 1'b0;
                        r_best <= '0;
                        r_vic  <= '0;
                        r_f    <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_dv   <= rd_en;
                    r_eidx <= r_idx[IDX_W-1:0];
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_dv) begin
                        if (res.match && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_eidx;
                            r_hit_rank <= e_rank;
                        end
                        if (res.empty && !r_emp) begin
                            r_emp     <= 1'b1;
                            r_emp_idx <= r_eidx;
                        end
                        if (res.above) begin
                            r_best <= e_rank;
                            r_vic  <= r_eidx;
                        end
                    end else if (r_idx == r_n) begin
                        // pick the frame: hit, else first empty, else oldest
                        if (r_hit) begin
                            r_f     <= r_hit_idx;
                            r_older <= {1'b0, r_hit_rank};
                        end else if (r_emp) begin
                            r_f     <= r_emp_idx;
                            r_older <= (RANK_W+1)'(FRAMES);
                        end else begin
                            r_f     <= r_vic;
                            r_older <= {1'b0, r_best};
                        end
                        r_idx   <= '0;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_dv   <= rd_en;
                    r_eidx <= r_idx[IDX_W-1:0];
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (upd_done) begin
                        r_valid[r_f] <= 1'b1;
                        r_fault   <= n_fault;
                        r_o_fault <= n_fault;
                        r_o_hit   <= r_hit;
                        r_o_fill  <= !r_hit && r_emp;
                        r_o_idx   <= f_ext[lpr_pkg::FIDX_W-1:0];
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(lpr_pkg::OUT_W - lpr_pkg::FAULT_W - lpr_pkg::FIDX_W){1'b0}},
                            r_o_fault, r_o_idx};
    assign m_axis_tuser  = {r_o_fill, r_o_hit};

`ifndef ASSERT_OFF
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser)))
        else $error("pending result changed while stalled");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_o_hit && r_o_fill))
        else $error("hit and fill flagged together");

    a_frame_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (CNT_W'(r_f) < r_n))
        else $error("chosen frame outside the active set");

    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fault >= $past(r_fault)))
        else $error("fault total went down");
`endif

endmodule
